### hdl/psev_pkg.sv
// ---------------------------------------------------------------------------
// psev_pkg: shared types and constants for the postfix stack evaluator
// Character codes, status codes and the command word that is passed from
// the front end through the queue to the execution back end.
// ---------------------------------------------------------------------------
package psev_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int WORD_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int DEPTH_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int DIGIT_W    = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;   // 32 + 5 bits of fields, padded to 5 bytes

   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_OP    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic                clear;
      kind_type            kind;
      op_type              op;
      logic [DIGIT_W-1:0]  digit;
   } cmd_type;

endpackage

### hdl/psev_ram.sv
// ---------------------------------------------------------------------------
// psev_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ---------------------------------------------------------------------------
module psev_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/psev_fifo.sv
// ---------------------------------------------------------------------------
// psev_fifo: short command queue between front end and back end
// Circular buffer of command words; read data comes straight from the head.
// ---------------------------------------------------------------------------
module psev_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  psev_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output psev_pkg::cmd_type rd_data
);
   import psev_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
   localparam logic [NW-1:0] FULLN = NW'(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign wr_ready = (count_ff != FULLN);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hdl/psev_front.sv
// ---------------------------------------------------------------------------
// psev_front: input stage and character decoder
// Registers each accepted item as a decoded command: digit, operator or
// no-op, with the clear flag carried along.
// ---------------------------------------------------------------------------
module psev_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psev_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output psev_pkg::cmd_type                 cmd
);
   import psev_pkg::*;

   logic              valid_ff, valid_in;
   cmd_type           cmd_ff;
   cmd_type           decoded;
   logic [CHAR_W-1:0] ch;
   logic [CHAR_W-1:0] ch_off;
   logic              accept;

   assign ch     = req_tdata[CHAR_W-1:0];
   assign ch_off = ch - CH_ZERO;

   always_comb begin
      decoded.clear = req_tuser;
      decoded.kind  = KIND_NONE;
      decoded.op    = OP_ADD;
      decoded.digit = ch_off[DIGIT_W-1:0];
      priority if (ch >= CH_ZERO && ch <= CH_NINE) begin
         decoded.kind = KIND_DIGIT;
      end else if (ch == CH_PLUS) begin
         decoded.kind = KIND_OP;
         decoded.op   = OP_ADD;
      end else if (ch == CH_MINUS) begin
         decoded.kind = KIND_OP;
         decoded.op   = OP_SUB;
      end else if (ch == CH_STAR) begin
         decoded.kind = KIND_OP;
         decoded.op   = OP_MUL;
      end else if (ch == CH_SLASH) begin
         decoded.kind = KIND_OP;
         decoded.op   = OP_DIV;
      end else begin
         decoded.kind = KIND_NONE;
      end
   end

   assign req_tready = !valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= decoded;
      end
   end

endmodule

### hdl/psev_div.sv
// ---------------------------------------------------------------------------
// psev_div: signed 32-bit divider, truncating toward zero
// Restoring radix-2 on magnitudes, one quotient bit per cycle, sign fixed
// on the way out. done is registered and pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
module psev_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [psev_pkg::WORD_W-1:0]   dividend,
   input  logic [psev_pkg::WORD_W-1:0]   divisor,
   output logic                          done,
   output logic [psev_pkg::WORD_W-1:0]   quotient
);
   import psev_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]  rem_ff, rem_in;
   logic [WORD_W-1:0]  quo_ff, quo_in;
   logic [WORD_W-1:0]  dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [WORD_W:0]    trial;
   logic [WORD_W:0]    diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = !diff[WORD_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_W - 1);
         rem_in  = '0;
         quo_in  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         dvs_in  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         neg_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (WORD_W'(0) - quo_ff) : quo_ff;

endmodule

### hdl/psev_back.sv
// ---------------------------------------------------------------------------
// psev_back: stack sequencer and arithmetic
// Keeps the stack in RAM with the top entry cached in a register, runs one
// command at a time and holds the result in an output register.
// ---------------------------------------------------------------------------
module psev_back #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  psev_pkg::cmd_type                 cmd,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psev_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [psev_pkg::STATUS_W-1:0]     rsp_tuser
);
   import psev_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
   localparam int PAD_W = RSP_DATA_W - WORD_W - DEPTH_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_EXEC = 4'b0100,
      S_DIVW = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      depth_ff, depth_in;
   logic [WORD_W-1:0]  top_ff, top_in;
   logic [WORD_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]  y_ff, y_in;
   op_type             op_ff, op_in;
   logic               under_ff, under_in;
   logic [AW-1:0]      widx_ff, widx_in;
   logic [CW-1:0]      ndepth_ff, ndepth_in;
   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  out_top_ff, out_top_in;
   logic [CW-1:0]      out_depth_ff, out_depth_in;
   status_type         out_status_ff, out_status_in;

   logic               slot_free;
   logic               take;
   logic [CW-1:0]      d;
   logic [WORD_W-1:0]  mul_lo;
   logic [WORD_W-1:0]  digit_word;

   logic               commit;
   logic [WORD_W-1:0]  commit_val;
   status_type         commit_status;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [WORD_W-1:0]  ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [WORD_W-1:0]  ram_rdata;

   logic               div_start;
   logic               div_done;
   logic [WORD_W-1:0]  div_q;

   logic [CW+DEPTH_W-1:0] depth_wide;

   psev_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   psev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x_ff),
      .divisor  (y_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign cmd_ready  = (state_ff == S_IDLE) && slot_free;
   assign take       = cmd_valid && cmd_ready;
   assign d          = cmd.clear ? '0 : depth_ff;
   assign mul_lo     = x_ff * y_ff;
   assign digit_word = WORD_W'(cmd.digit);

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      op_in         = op_ff;
      under_in      = under_ff;
      widx_in       = widx_ff;
      ndepth_in     = ndepth_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_top_in    = out_top_ff;
      out_depth_in  = out_depth_ff;
      out_status_in = out_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(d);
      ram_wdata     = digit_word;
      ram_raddr     = AW'(d - CW'(2));
      div_start     = 1'b0;
      commit        = 1'b0;
      commit_val    = '0;
      commit_status = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (cmd.kind)
                  KIND_DIGIT: begin
                     out_valid_in = 1'b1;
                     if (d == FULL) begin
                        // full stack: digit dropped, top unchanged
                        depth_in      = d;
                        out_top_in    = top_ff;
                        out_depth_in  = d;
                        out_status_in = ST_OVER;
                     end else begin
                        ram_we        = 1'b1;
                        top_in        = digit_word;
                        depth_in      = d + CW'(1);
                        out_top_in    = digit_word;
                        out_depth_in  = d + CW'(1);
                        out_status_in = ST_OK;
                     end
                  end
                  KIND_OP: begin
                     op_in    = cmd.op;
                     depth_in = d;
                     y_in     = (d != '0) ? top_ff : '0;
                     x_in     = '0;
                     if (d >= CW'(2)) begin
                        widx_in   = AW'(d - CW'(2));
                        ndepth_in = d - CW'(1);
                        under_in  = 1'b0;
                        state_in  = S_LOAD;
                     end else begin
                        // short stack: missing operands read as zero
                        widx_in   = '0;
                        ndepth_in = CW'(1);
                        under_in  = 1'b1;
                        state_in  = S_EXEC;
                     end
                  end
                  default: begin
                     depth_in      = d;
                     out_valid_in  = 1'b1;
                     out_top_in    = (d != '0) ? top_ff : '0;
                     out_depth_in  = d;
                     out_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_LOAD: begin
            x_in     = ram_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_ADD: begin
                  commit        = 1'b1;
                  commit_val    = x_ff + y_ff;
                  commit_status = under_ff ? ST_UNDER : ST_OK;
               end
               OP_SUB: begin
                  commit        = 1'b1;
                  commit_val    = x_ff - y_ff;
                  commit_status = under_ff ? ST_UNDER : ST_OK;
               end
               OP_MUL: begin
                  commit        = 1'b1;
                  commit_val    = mul_lo;
                  commit_status = under_ff ? ST_UNDER : ST_OK;
               end
               OP_DIV: begin
                  if (y_ff == '0) begin
                     // zero divisor pushes 0; underflow takes precedence
                     commit        = 1'b1;
                     commit_val    = '0;
                     commit_status = under_ff ? ST_UNDER : ST_DIVZ;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIVW;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIVW: begin
            if (div_done) begin
               commit        = 1'b1;
               commit_val    = div_q;
               commit_status = under_ff ? ST_UNDER : ST_OK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (commit) begin
         ram_we        = 1'b1;
         ram_waddr     = widx_ff;
         ram_wdata     = commit_val;
         top_in        = commit_val;
         depth_in      = ndepth_ff;
         out_valid_in  = 1'b1;
         out_top_in    = commit_val;
         out_depth_in  = ndepth_ff;
         out_status_in = commit_status;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      op_ff         <= op_in;
      under_ff      <= under_in;
      widx_ff       <= widx_in;
      ndepth_ff     <= ndepth_in;
      out_top_ff    <= out_top_in;
      out_depth_ff  <= out_depth_in;
      out_status_ff <= out_status_in;
   end

   assign depth_wide = {{DEPTH_W{1'b0}}, out_depth_ff};
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, depth_wide[DEPTH_W-1:0], out_top_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

### hdl/postfix_stack_evaluator_unit.sv
// ---------------------------------------------------------------------------
// postfix_stack_evaluator_unit: reverse-Polish evaluator on a word stack
// Throughput: one digit or no-op per cycle while results are accepted and
// the back-end sequencer is free; an operator holds that sequencer until its
// result is committed, and / also waits there on the 32-step divider.
// Synchronous active-high reset empties the stack and the queue and drops
// any pending result; stack RAM contents are not cleared.
// ---------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF,
   parameter int QUEUE_DEPTH = psev_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psev_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] ch
   input  logic                              req_tuser,  // [0] clear_first
   // result output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [39:37] zero padding
   output logic [psev_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [31:0] top_value, [36:32] stack_depth
   output logic [psev_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);
   import psev_pkg::*;

   localparam logic [DEPTH_W-1:0] FULL_LO = DEPTH_W'(STACK_DEPTH);

   // front end -> queue
   logic    fr_valid;
   logic    fr_ready;
   cmd_type fr_cmd;

   // queue -> back end
   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   // Front: registers each character and decodes it into a command.
   psev_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (fr_valid),
      .cmd_ready  (fr_ready),
      .cmd        (fr_cmd)
   );

   // Queue: lets the front keep taking characters while a divide runs.
   psev_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_data  (fr_cmd),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_cmd)
   );

   // Back: stack RAM, top-of-stack cache, ALU, divider, result register.
   psev_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // No result survives reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A dropped push only happens on a full stack.
   a_over_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_OVER) |-> (rsp_tdata[36:32] == FULL_LO))
      else $error("overflow status with stack not full");

   // An empty stack reports a zero top value.
   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && STACK_DEPTH < 32 && rsp_tdata[36:32] == '0)
         |-> (rsp_tdata[31:0] == '0))
      else $error("nonzero top value on empty stack");

   // Underflow and divide-by-zero always leave one pushed entry.
   a_err_pushes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && STACK_DEPTH < 32 && (rsp_tuser == ST_UNDER || rsp_tuser == ST_DIVZ))
         |-> (rsp_tdata[36:32] != '0))
      else $error("operator result missing from stack");

endmodule

### sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for postfix_stack_evaluator_unit
// Streams expression characters into the evaluator, predicts the stack top,
// depth and status for every item, and compares each result in order.
// Runs a short directed list, then random expressions, stack-fill bursts,
// wraparound division runs and noise, under four idling phases.
// ---------------------------------------------------------------------------
module testbench;
   import psev_pkg::*;

   localparam int STACK_SIZE   = STACK_DEPTH_DEF;
   localparam int PHASE_ITEMS  = 450;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      bit                clear;
      logic [CHAR_W-1:0] ch;
   } char_item_type;

   typedef struct {
      logic [WORD_W-1:0]  top;
      logic [DEPTH_W-1:0] depth;
      status_type         status;
   } stack_view_type;

   logic clock;
   logic reset;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] ch
   logic                  req_tuser  = 1'b0; // [0] clear_first
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] top, [36:32] depth, [39:37] zero
   logic [STATUS_W-1:0]   rsp_tuser;         // [1:0] status

   char_item_type  char_queue[$];
   stack_view_type expected_views[$];
   char_item_type  next_char;
   stack_view_type want;

   // predictor state
   logic [WORD_W-1:0] word_stack[STACK_SIZE];
   int                stack_count = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int phase_count    = 0;
   int errors         = 0;
   int cycle_count    = 0;

   logic [CHAR_W-1:0] op_chars[4];

   postfix_stack_evaluator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // stack after one character, updates the predictor state
   function automatic stack_view_type evaluate_char(bit clr, logic [CHAR_W-1:0] ch);
      stack_view_type    v;
      logic [WORD_W-1:0] x, y, mx, my, q, res;
      bit                under;
      bit                divz;
      v.status = ST_OK;
      under    = 1'b0;
      divz     = 1'b0;
      if (clr)
         stack_count = 0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         if (stack_count < STACK_SIZE) begin
            word_stack[stack_count] = WORD_W'(ch - CH_ZERO);
            stack_count++;
         end else begin
            v.status = ST_OVER;   // push dropped
         end
      end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
         // pop y, then x; an empty pop yields zero
         if (stack_count == 0) begin
            under = 1'b1;
            y     = '0;
         end else begin
            stack_count--;
            y = word_stack[stack_count];
         end
         if (stack_count == 0) begin
            under = 1'b1;
            x     = '0;
         end else begin
            stack_count--;
            x = word_stack[stack_count];
         end
         case (ch)
            CH_PLUS:  res = x + y;
            CH_MINUS: res = x - y;
            CH_STAR:  res = x * y;
            default: begin
               if (y == '0) begin
                  res  = '0;
                  divz = 1'b1;
               end else begin
                  // magnitude divide, sign fixed after: truncates toward zero
                  mx  = x[WORD_W-1] ? -x : x;
                  my  = y[WORD_W-1] ? -y : y;
                  q   = mx / my;
                  res = (x[WORD_W-1] ^ y[WORD_W-1]) ? -q : q;
               end
            end
         endcase
         word_stack[stack_count] = res;   // two pops always leave room
         stack_count++;
         if (under)
            v.status = ST_UNDER;
         else if (divz)
            v.status = ST_DIVZ;
      end
      v.top   = (stack_count > 0) ? word_stack[stack_count-1] : '0;
      v.depth = DEPTH_W'(stack_count);
      return v;
   endfunction

   task automatic add_char(bit clr, logic [CHAR_W-1:0] ch);
      char_item_type it;
      it.clear = clr;
      it.ch    = ch;
      char_queue.push_back(it);
      phase_count++;
   endtask

   task automatic add_digit(bit clr, int d);
      add_char(clr, CH_ZERO + CHAR_W'(d));
   endtask

   // random well-formed postfix expression, occasionally left unbalanced
   task automatic add_expression();
      int len;
      int d;
      int digit;
      bit clr;
      len = $urandom_range(2, 24);
      d   = 0;
      clr = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if (d < 2 || (d < STACK_SIZE && $urandom_range(0, 1) == 1)) begin
            // zero often enough to hit the zero divisor
            digit = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
            add_digit(clr, digit);
            d++;
         end else begin
            add_char(clr, op_chars[$urandom_range(0, 3)]);
            d--;
         end
         clr = 1'b0;
      end
      while (d > 1 && $urandom_range(0, 3) != 0) begin
         add_char(1'b0, op_chars[$urandom_range(0, 3)]);
         d--;
      end
   endtask

   // fill the stack to its top or past it, then fold a few entries
   task automatic add_fill_burst();
      int n;
      n = $urandom_range(STACK_SIZE, STACK_SIZE + 4);
      for (int i = 0; i < n; i++)
         add_digit(i == 0, $urandom_range(0, 9));
      repeat ($urandom_range(0, 3))
         add_char(1'b0, op_chars[$urandom_range(0, 3)]);
   endtask

   // 8^10 * 2 wraps to the most negative word, then divide by minus one (or, now and then, + - *)
   task automatic add_min_div();
      for (int i = 0; i < 10; i++)
         add_digit(i == 0, 8);
      repeat (9)
         add_char(1'b0, CH_STAR);
      add_digit(1'b0, 2);
      add_char(1'b0, CH_STAR);
      add_digit(1'b0, 0);
      add_digit(1'b0, 1);
      add_char(1'b0, CH_MINUS);
      add_char(1'b0, ($urandom_range(0, 3) == 0) ? op_chars[$urandom_range(0, 2)]
                                                 : CH_SLASH);
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 5))
         add_char(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
   endtask

   task automatic add_directed();
      add_char(1'b1, CH_PLUS);     // both pops from empty
      add_char(1'b1, CH_SLASH);    // underflow beats zero divisor
      add_digit(1'b1, 9);
      add_digit(1'b0, 0);
      add_char(1'b0, CH_SLASH);    // divide by zero
      add_digit(1'b0, 7);
      add_char(1'b0, CH_MINUS);    // 0 - 7
      add_digit(1'b0, 3);
      add_char(1'b0, CH_SLASH);    // -7 / 3 truncates to -2
      add_digit(1'b0, 2);
      add_char(1'b0, CH_STAR);
      add_digit(1'b0, 5);
      add_char(1'b0, CH_PLUS);
      add_char(1'b0, 8'h00);
      add_char(1'b1, 8'hFF);       // clear with a non-operator
      add_char(1'b0, 8'h61);
      add_digit(1'b0, 1);
      add_char(1'b0, CH_MINUS);    // one entry, second pop underflows
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_views.push_back(evaluate_char(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (char_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_char = char_queue.pop_front();
               req_tdata  <= next_char.ch;
               req_tuser  <= next_char.clear;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_views.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual data %h status %h",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = expected_views.pop_front();
               if (rsp_tdata[31:0] !== want.top) begin
                  $display("%0t: top_value: expected %h, actual %h",
                           $time, want.top, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[36:32] !== want.depth) begin
                  $display("%0t: stack_depth: expected %0d, actual %0d",
                           $time, want.depth, rsp_tdata[36:32]);
                  errors++;
               end
               if (rsp_tdata[39:37] !== 3'b000) begin
                  $display("%0t: padding: expected 0, actual %b", $time, rsp_tdata[39:37]);
                  errors++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status: expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int pick;
      op_chars[0] = CH_PLUS;
      op_chars[1] = CH_MINUS;
      op_chars[2] = CH_STAR;
      op_chars[3] = CH_SLASH;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_directed();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         while (phase_count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               add_expression();
            else if (pick < 70)
               add_fill_burst();
            else if (pick < 75)
               add_min_div();
            else
               add_noise();
         end
         phase_count = 0;
         while (char_queue.size() > 0)
            @(posedge clock);
      end

      while (req_tvalid || expected_views.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_views.size() != 0) begin
         $display("%0t: missing results: expected %0d more, actual 0",
                  $time, expected_views.size());
         errors++;
      end
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
hdl/psev_pkg.sv
hdl/psev_ram.sv
hdl/psev_fifo.sv
hdl/psev_front.sv
hdl/psev_div.sv
hdl/psev_back.sv
hdl/postfix_stack_evaluator_unit.sv
sim/testbench.sv
